[rtl/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int PRI_W = 16;
    localparam int PAY_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PRI_W-1:0] priority_req;
        logic [PAY_W-1:0] payload;
    } t_in;

    typedef struct packed {
        logic             ok;
        logic [PRI_W-1:0] out_priority;
        logic [PAY_W-1:0] out_payload;
        logic             is_empty;
        logic             is_full;
    } t_out;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] data;
    } t_entry;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry entry;
    } t_cell_ctl;

endpackage

[rtl/stable_priority_queue_top.sv]
// Stable priority queue built as a chain of sorted register cells.
// An accepted transaction's result is in the output register in the next cycle.
// Throughput: one transaction per cycle unless o_stall is set; every cell updates
// in parallel from neighbors; insert, remove, clear each finish in the accepting cycle.
// Reset clears the entry count and the output valid; cell contents are left as is
// and only slots below the count are ever read, so no clearing pass is needed.
module stable_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  spq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output spq_pkg::t_out o_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Control and output registers
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_out_valid;
    logic           n_out_valid;
    spq_pkg::t_out  r_out;
    spq_pkg::t_out  n_out;

    logic           in_accept;
    logic           is_empty_now;
    logic           is_full_now;
    spq_pkg::t_cell_ctl cell_ctl;

    // Chain wiring: entry and keep flag of each cell.
    spq_pkg::t_entry cell_entry [CAPACITY];
    logic            cell_keep  [CAPACITY];

    // A new transaction enters whenever the result register is free or draining.
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == CW'(CAPACITY));

    always_comb begin
        cell_ctl.ins   = in_accept && (i_data.op == spq_pkg::OP_INSERT) && !is_full_now;
        cell_ctl.rem   = in_accept && (i_data.op == spq_pkg::OP_REMOVE) && !is_empty_now;
        cell_ctl.entry = '{pri: i_data.priority_req, data: i_data.payload};
    end

    // The cell chain: slot 0 is the head. An insert lands just after the last
    // cell that keeps its entry; everything behind it moves one slot back.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;
        logic            left_keep;

        if (g == 0) begin : g_head
            assign left_entry = cell_entry[0];
            assign left_keep  = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[g-1];
            assign left_keep  = cell_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_entry[g];
        end else begin : g_mid
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_occupied    (CW'(g) < r_count),
            .i_left_keep   (left_keep),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[g]),
            .o_keep        (cell_keep[g])
        );
    end

    // Count update and result formation
    always_comb begin
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        if (in_accept) begin
            n_out_valid        = 1'b1;
            n_out.ok           = 1'b0;
            n_out.out_priority = '0;
            n_out.out_payload  = '0;
            unique case (i_data.op)
                spq_pkg::OP_INSERT: begin
                    if (!is_full_now) begin
                        n_count  = r_count + CW'(1);
                        n_out.ok = 1'b1;
                    end
                end
                spq_pkg::OP_REMOVE: begin
                    if (!is_empty_now) begin
                        n_count            = r_count - CW'(1);
                        n_out.ok           = 1'b1;
                        n_out.out_priority = cell_entry[0].pri;
                        n_out.out_payload  = cell_entry[0].data;
                    end
                end
                spq_pkg::OP_CLEAR: begin
                    n_count  = '0;
                    n_out.ok = 1'b1;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            n_out.is_empty = (n_count == '0);
            n_out.is_full  = (n_count == CW'(CAPACITY));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // Count never runs past the number of cells.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A shown result's flags agree with the live count.
    a_flags_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.is_empty == (r_count == '0))
                 && (o_data.is_full == (r_count == CW'(CAPACITY))))
        else $error("result flags disagree with entry count");

    // An insert into a non-full queue succeeds and leaves it non-empty.
    a_insert_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_data.op == spq_pkg::OP_INSERT && !is_full_now)
        |=> (o_valid && o_data.ok && !o_data.is_empty))
        else $error("insert into non-full queue not reported as success");

    // A remove on an empty queue returns zeros and fails.
    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_data.op == spq_pkg::OP_REMOVE && is_empty_now)
        |=> (o_valid && !o_data.ok && o_data.out_priority == '0
             && o_data.out_payload == '0))
        else $error("remove on empty queue returned data");
`endif

endmodule

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_left_keep,
    input  spq_pkg::t_entry    i_left_entry,
    input  spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_keep
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Stays put on insert when it outranks or ties the new entry.
    assign o_keep  = i_occupied && (r_entry.pri >= i_ctl.entry.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_ctl.entry;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
